[hw/rtl/bml_pkg.sv]
// bml_pkg: shared types and constants for the bilinear map lookup block
// used by bml_ctrl, bml_dp and bilinear_map_lookup; no dependencies
package bml_pkg;

  localparam int DEF_MAX_X_POINTS = 16;
  localparam int DEF_MAX_Y_POINTS = 16;
  localparam int FRAC_BITS        = 16;

  // operation codes carried in s_tuser
  localparam logic [1:0] OP_LOOKUP   = 2'd0;
  localparam logic [1:0] OP_WR_X     = 2'd1;
  localparam logic [1:0] OP_WR_Y     = 2'd2;
  localparam logic [1:0] OP_WR_CELL  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_X_COUNT     = 3'd0;
  localparam logic [2:0] REG_Y_COUNT     = 3'd1;
  localparam logic [2:0] REG_CELL_TYPE   = 3'd2;
  localparam logic [2:0] REG_RESULT_MODE = 3'd3;
  localparam logic [2:0] REG_SCALE       = 3'd4;
  localparam logic [2:0] REG_OFFSET      = 3'd5;

  // cell encodings
  localparam logic [2:0] CT_Q16 = 3'd0;
  localparam logic [2:0] CT_U8  = 3'd1;
  localparam logic [2:0] CT_U16 = 3'd2;
  localparam logic [2:0] CT_S8  = 3'd3;
  localparam logic [2:0] CT_S16 = 3'd4;

  // result modes
  localparam logic [1:0] RM_TYPED = 2'd0;
  localparam logic [1:0] RM_U8    = 2'd1;
  localparam logic [1:0] RM_U16   = 2'd2;

  // breakpoint read address select
  typedef enum logic [2:0] {
    RS_NONE,
    RS_LAST,
    RS_FIRST,
    RS_SECOND,
    RS_NEXT
  } rd_sel_t;

  // multiplier operand / accumulate target select
  typedef enum logic [1:0] {
    MS_R0,
    MS_R1,
    MS_I,
    MS_S
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     axis;       // 0 x axis, 1 y axis
    rd_sel_t  rd_sel;
    logic     set_last;
    logic     set_first;
    logic     lo_load;
    logic     k_clear;
    logic     k_inc;
    logic     div_init;
    logic     div_step;
    logic [1:0] cell_sel;
    logic     cell_cap;
    logic [1:0] cap_sel;
    mul_sel_t mul_sel;
    logic     add_en;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic ge;         // axis input >= breakpoint just read
    logic out_busy;   // output register full and not taken this cycle
  } sts_t;

endpackage

[hw/rtl/bml_ctrl.sv]
// bml_ctrl: sequencer for the bilinear map lookup
// depends on bml_pkg; drives bml_dp through cmd_t and reads sts_t
module bml_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic [1:0]           op,
  output logic                 s_tready,
  input  bml_pkg::sts_t        sts,
  output bml_pkg::cmd_t        cmd
);

  typedef enum logic [19:0] {
    S_IDLE      = 20'h00001,
    S_RD_LAST   = 20'h00002,
    S_CHK_LAST  = 20'h00004,
    S_CHK_FIRST = 20'h00008,
    S_SCAN      = 20'h00010,
    S_DIV       = 20'h00020,
    S_C0        = 20'h00040,
    S_C1        = 20'h00080,
    S_C2        = 20'h00100,
    S_C3        = 20'h00200,
    S_C4        = 20'h00400,
    S_M_R0      = 20'h00800,
    S_A_R0      = 20'h01000,
    S_M_R1      = 20'h02000,
    S_A_R1      = 20'h04000,
    S_M_I       = 20'h08000,
    S_A_I       = 20'h10000,
    S_M_S       = 20'h20000,
    S_FIN       = 20'h40000
  } state_t;

  localparam int CNTW = $clog2(bml_pkg::FRAC_BITS);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(bml_pkg::FRAC_BITS - 1);

  state_t          state, state_next;
  logic            axis, axis_next;
  logic [CNTW-1:0] cnt, cnt_next;
  state_t          axis_done;

  assign s_tready = (state == S_IDLE);
  assign axis_done = axis ? S_C0 : S_RD_LAST;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.axis   = axis;
    cmd.rd_sel = bml_pkg::RS_NONE;
    cmd.mul_sel = bml_pkg::MS_R0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          if (op == bml_pkg::OP_LOOKUP) begin
            axis_next  = 1'b0;
            state_next = S_RD_LAST;
          end
        end
      end
      S_RD_LAST: begin
        cmd.rd_sel = bml_pkg::RS_LAST;
        state_next = S_CHK_LAST;
      end
      S_CHK_LAST: begin
        if (sts.ge) begin
          cmd.set_last = 1'b1;
          axis_next    = 1'b1;
          state_next   = axis_done;
        end else begin
          cmd.rd_sel = bml_pkg::RS_FIRST;
          state_next = S_CHK_FIRST;
        end
      end
      S_CHK_FIRST: begin
        if (!sts.ge) begin
          cmd.set_first = 1'b1;
          axis_next     = 1'b1;
          state_next    = axis_done;
        end else begin
          cmd.lo_load = 1'b1;
          cmd.k_clear = 1'b1;
          cmd.rd_sel  = bml_pkg::RS_SECOND;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.ge) begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else begin
          cmd.lo_load = 1'b1;
          cmd.k_inc   = 1'b1;
          cmd.rd_sel  = bml_pkg::RS_NEXT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          axis_next  = 1'b1;
          state_next = axis_done;
        end
      end
      S_C0: begin
        cmd.cell_sel = 2'd0;
        state_next   = S_C1;
      end
      S_C1: begin
        cmd.cell_sel = 2'd1;
        cmd.cell_cap = 1'b1;
        cmd.cap_sel  = 2'd0;
        state_next   = S_C2;
      end
      S_C2: begin
        cmd.cell_sel = 2'd2;
        cmd.cell_cap = 1'b1;
        cmd.cap_sel  = 2'd1;
        state_next   = S_C3;
      end
      S_C3: begin
        cmd.cell_sel = 2'd3;
        cmd.cell_cap = 1'b1;
        cmd.cap_sel  = 2'd2;
        state_next   = S_C4;
      end
      S_C4: begin
        cmd.cell_cap = 1'b1;
        cmd.cap_sel  = 2'd3;
        state_next   = S_M_R0;
      end
      S_M_R0: begin
        cmd.mul_sel = bml_pkg::MS_R0;
        state_next  = S_A_R0;
      end
      S_A_R0: begin
        cmd.mul_sel = bml_pkg::MS_R0;
        cmd.add_en  = 1'b1;
        state_next  = S_M_R1;
      end
      S_M_R1: begin
        cmd.mul_sel = bml_pkg::MS_R1;
        state_next  = S_A_R1;
      end
      S_A_R1: begin
        cmd.mul_sel = bml_pkg::MS_R1;
        cmd.add_en  = 1'b1;
        state_next  = S_M_I;
      end
      S_M_I: begin
        cmd.mul_sel = bml_pkg::MS_I;
        state_next  = S_A_I;
      end
      S_A_I: begin
        cmd.mul_sel = bml_pkg::MS_I;
        cmd.add_en  = 1'b1;
        state_next  = S_M_S;
      end
      S_M_S: begin
        cmd.mul_sel = bml_pkg::MS_S;
        state_next  = S_FIN;
      end
      S_FIN: begin
        cmd.mul_sel = bml_pkg::MS_S;
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[hw/rtl/bml_dp.sv]
// bml_dp: stores, config registers, divider, shared multiplier and output register
// depends on bml_pkg; sequenced by bml_ctrl through cmd_t
module bml_dp #(
  parameter int MAX_X_POINTS = bml_pkg::DEF_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = bml_pkg::DEF_MAX_Y_POINTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    op,
  input  logic [7:0]    entry_index,
  input  logic [31:0]   entry_data,
  input  logic [31:0]   x_value,
  input  logic [31:0]   y_value,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  bml_pkg::cmd_t cmd,
  output bml_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   result,
  output logic          saturated,
  output logic [3:0]    x_cell,
  output logic [3:0]    y_cell,
  output logic [15:0]   x_frac,
  output logic [15:0]   y_frac
);

  localparam int XW     = $clog2(MAX_X_POINTS);
  localparam int YW     = $clog2(MAX_Y_POINTS);
  localparam int AW     = (XW > YW) ? XW : YW;
  localparam int CXW    = $clog2(MAX_X_POINTS + 1);
  localparam int CYW    = $clog2(MAX_Y_POINTS + 1);
  localparam int CDEPTH = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int CW     = $clog2(CDEPTH);
  localparam int PW     = CXW + YW + 1;
  localparam int FB     = bml_pkg::FRAC_BITS;

  // breakpoint and cell memories
  logic [31:0] x_store [MAX_X_POINTS];
  logic [31:0] y_store [MAX_Y_POINTS];
  logic [31:0] c_store [CDEPTH];

  logic [4:0]  x_count, y_count;
  logic [2:0]  cell_type;
  logic [1:0]  result_mode;
  logic signed [31:0] scale, offset;

  logic signed [31:0] x_in, y_in;
  logic signed [31:0] rd_x, rd_y, c_rd;
  logic signed [31:0] lo;
  logic [AW-1:0] k;
  logic [XW-1:0] ix;
  logic [YW-1:0] iy;
  logic [FB-1:0] tx, ty;
  logic [33:0]   rem;
  logic [32:0]   dvs;

  logic signed [32:0] c00, c10, c01, c11, r0, r1, interp;
  logic signed [66:0] prod;

  logic [CXW-1:0] cx;
  logic [CYW-1:0] cy;
  logic [AW-1:0]  rd_addr;
  logic [XW-1:0]  ix1, xcol;
  logic [YW-1:0]  iy1, yrow;
  logic [PW-1:0]  caddr_full;
  logic [CW-1:0]  caddr;
  logic [1:0]     mode;
  logic [2:0]     kind;
  logic signed [31:0] v_cur, bp_cur;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] lerp_sum, scl_sum;
  logic [33:0]   rem_sh;
  logic [31:0]   res_val;
  logic          sat_val;
  logic          wr_acc;

  // effective counts: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (x_count == 5'd0) begin
      cx = CXW'(1);
    end else if (32'(x_count) > MAX_X_POINTS) begin
      cx = CXW'(MAX_X_POINTS);
    end else begin
      cx = CXW'(x_count);
    end
    if (y_count == 5'd0) begin
      cy = CYW'(1);
    end else if (32'(y_count) > MAX_Y_POINTS) begin
      cy = CYW'(MAX_Y_POINTS);
    end else begin
      cy = CYW'(y_count);
    end
  end

  assign mode = (result_mode == bml_pkg::RM_U8 || result_mode == bml_pkg::RM_U16) ?
                result_mode : bml_pkg::RM_TYPED;

  always_comb begin
    if (mode == bml_pkg::RM_U8) begin
      kind = bml_pkg::CT_U8;
    end else if (mode == bml_pkg::RM_U16) begin
      kind = bml_pkg::CT_U16;
    end else if (cell_type <= bml_pkg::CT_S16) begin
      kind = cell_type;
    end else begin
      kind = bml_pkg::CT_Q16;
    end
  end

  function automatic logic signed [32:0] decode(input logic [31:0] w, input logic [2:0] kd);
    logic signed [32:0] d;
    unique case (kd)
      bml_pkg::CT_U8:  d = $signed({1'b0, w[7:0], 24'd0}) >>> 8;
      bml_pkg::CT_U16: d = $signed({1'b0, w[15:0], 16'd0});
      bml_pkg::CT_S8:  d = $signed({{9{w[7]}}, w[7:0], 16'd0});
      bml_pkg::CT_S16: d = $signed({w[15], w[15:0], 16'd0});
      default:         d = $signed({w[31], w});
    endcase
    return d;
  endfunction

  assign v_cur  = cmd.axis ? y_in : x_in;
  assign bp_cur = cmd.axis ? rd_y : rd_x;
  assign sts.ge = (v_cur >= bp_cur);
  assign sts.out_busy = out_valid && !out_ready;

  // breakpoint read address
  always_comb begin
    unique case (cmd.rd_sel)
      bml_pkg::RS_LAST: begin
        rd_addr = cmd.axis ? AW'(cy - 1'b1) : AW'(cx - 1'b1);
      end
      bml_pkg::RS_FIRST:  rd_addr = '0;
      bml_pkg::RS_SECOND: rd_addr = AW'(1);
      bml_pkg::RS_NEXT:   rd_addr = k + AW'(2);
      default:            rd_addr = '0;
    endcase
  end

  // upper neighbours and cell address
  assign ix1 = (CXW'(ix) + 1'b1 < cx) ? ix + 1'b1 : ix;
  assign iy1 = (CYW'(iy) + 1'b1 < cy) ? iy + 1'b1 : iy;
  assign xcol = cmd.cell_sel[0] ? ix1 : ix;
  assign yrow = cmd.cell_sel[1] ? iy1 : iy;
  assign caddr_full = PW'(yrow) * PW'(cx) + PW'(xcol);
  assign caddr = caddr_full[CW-1:0];

  assign wr_acc = cmd.load_in;

  always_ff @(posedge clk) begin
    if (wr_acc && op == bml_pkg::OP_WR_X && 32'(entry_index) < MAX_X_POINTS) begin
      x_store[XW'(entry_index)] <= entry_data;
    end
    if (wr_acc && op == bml_pkg::OP_WR_Y && 32'(entry_index) < MAX_Y_POINTS) begin
      y_store[YW'(entry_index)] <= entry_data;
    end
    if (wr_acc && op == bml_pkg::OP_WR_CELL && 32'(entry_index) < CDEPTH) begin
      c_store[CW'(entry_index)] <= entry_data;
    end
    rd_x <= x_store[rd_addr[XW-1:0]];
    rd_y <= y_store[rd_addr[YW-1:0]];
    c_rd <= c_store[caddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_count     <= 5'd1;
      y_count     <= 5'd1;
      cell_type   <= bml_pkg::CT_Q16;
      result_mode <= bml_pkg::RM_TYPED;
      scale       <= 32'sd65536;
      offset      <= 32'sd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bml_pkg::REG_X_COUNT:     x_count     <= cfg_data[4:0];
        bml_pkg::REG_Y_COUNT:     y_count     <= cfg_data[4:0];
        bml_pkg::REG_CELL_TYPE:   cell_type   <= cfg_data[2:0];
        bml_pkg::REG_RESULT_MODE: result_mode <= cfg_data[1:0];
        bml_pkg::REG_SCALE:       scale       <= cfg_data;
        bml_pkg::REG_OFFSET:      offset      <= cfg_data;
        default: ;
      endcase
    end
  end

  // search and restoring division, one quotient bit per cycle
  assign rem_sh = {rem[32:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_in <= x_value;
      y_in <= y_value;
    end
    if (cmd.lo_load) begin
      lo <= bp_cur;
    end
    if (cmd.k_clear) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
    if (cmd.set_last) begin
      if (cmd.axis) begin
        iy <= YW'(cy - 1'b1);
        ty <= '0;
      end else begin
        ix <= XW'(cx - 1'b1);
        tx <= '0;
      end
    end
    if (cmd.set_first) begin
      if (cmd.axis) begin
        iy <= '0;
        ty <= '0;
      end else begin
        ix <= '0;
        tx <= '0;
      end
    end
    if (cmd.div_init) begin
      rem <= 34'($signed({v_cur[31], v_cur}) - $signed({lo[31], lo}));
      dvs <= 33'($signed({bp_cur[31], bp_cur}) - $signed({lo[31], lo}));
      if (cmd.axis) begin
        iy <= k[YW-1:0];
        ty <= '0;
      end else begin
        ix <= k[XW-1:0];
        tx <= '0;
      end
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
      end else begin
        rem <= rem_sh;
      end
      if (cmd.axis) begin
        ty <= {ty[FB-2:0], (rem_sh >= {1'b0, dvs})};
      end else begin
        tx <= {tx[FB-2:0], (rem_sh >= {1'b0, dvs})};
      end
    end
  end

  // shared multiplier, product registered every cycle
  always_comb begin
    unique case (cmd.mul_sel)
      bml_pkg::MS_R0: begin
        mul_a = 34'(c10) - 34'(c00);
        mul_b = $signed({17'd0, tx});
      end
      bml_pkg::MS_R1: begin
        mul_a = 34'(c11) - 34'(c01);
        mul_b = $signed({17'd0, tx});
      end
      bml_pkg::MS_I: begin
        mul_a = 34'(r1) - 34'(r0);
        mul_b = $signed({17'd0, ty});
      end
      default: begin
        mul_a = 34'(interp);
        mul_b = 33'(scale);
      end
    endcase
  end

  always_comb begin
    unique case (cmd.mul_sel)
      bml_pkg::MS_R0: lerp_sum = 67'(c00) + (prod >>> FB);
      bml_pkg::MS_R1: lerp_sum = 67'(c01) + (prod >>> FB);
      default:        lerp_sum = 67'(r0) + (prod >>> FB);
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 67'(mul_a) * 67'(mul_b);
    if (cmd.cell_cap) begin
      unique case (cmd.cap_sel)
        2'd0: c00 <= decode(c_rd, kind);
        2'd1: c10 <= decode(c_rd, kind);
        2'd2: c01 <= decode(c_rd, kind);
        default: c11 <= decode(c_rd, kind);
      endcase
    end
    if (cmd.add_en) begin
      unique case (cmd.mul_sel)
        bml_pkg::MS_R0: r0 <= lerp_sum[32:0];
        bml_pkg::MS_R1: r1 <= lerp_sum[32:0];
        default:        interp <= lerp_sum[32:0];
      endcase
    end
  end

  // final result per mode, with 32-bit saturation of the scaled value
  assign scl_sum = (prod >>> FB) + 67'(offset);

  always_comb begin
    sat_val = 1'b0;
    if (mode == bml_pkg::RM_U8) begin
      res_val = {24'd0, interp[23:16]};
    end else if (mode == bml_pkg::RM_U16) begin
      res_val = {16'd0, interp[31:16]};
    end else if (kind == bml_pkg::CT_Q16) begin
      res_val = interp[31:0];
    end else if (scl_sum > 67'sd2147483647) begin
      res_val = 32'h7FFF_FFFF;
      sat_val = 1'b1;
    end else if (scl_sum < -67'sd2147483648) begin
      res_val = 32'h8000_0000;
      sat_val = 1'b1;
    end else begin
      res_val = scl_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      result    <= res_val;
      saturated <= sat_val;
      x_cell    <= 4'(ix);
      y_cell    <= 4'(iy);
      x_frac    <= tx;
      y_frac    <= ty;
    end
  end

endmodule

[hw/rtl/bilinear_map_lookup.sv]
// bilinear_map_lookup: top level of the bilinear calibration-map lookup
// depends on bml_pkg, bml_ctrl and bml_dp
//
// usage:
//   s_* stream carries items: s_tuser is the operation (lookup, write x
//   breakpoint, write y breakpoint, write cell); s_tdata holds entry_index,
//   entry_data, x_value, y_value from the lowest bit up.
//   writes give no result; a lookup gives one result on m_*.
//   cfg_* channel writes the registers (count, type, mode, scale, offset); it
//   is always ready; the user must write only while the block is idle; unenforced.
// lookup sequence:
//   per axis the last breakpoint is read and compared first, then the first;
//   an input at or above the last or below the first ends the axis there. an
//   inner input goes through a linear search (up to MAX_POINTS-1 breakpoints
//   compared) and a restoring division for the 16-bit fraction; then the four
//   cells are read; the shared multiplier forms the row and column blends
//   and the scaling; then the block goes idle. one item is in work at a time.
// reset: rst resets the sequencer, clears output valid, loads config defaults;
//   stores hold nothing defined until written. no clearing pass.
// stall: a result waits in the output register; the next item is accepted
//   meanwhile and a finished lookup holds until the register frees.
module bilinear_map_lookup #(
  parameter int MAX_X_POINTS = bml_pkg::DEF_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = bml_pkg::DEF_MAX_Y_POINTS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // entry_index, entry_data, x_value, y_value
  input  logic [1:0]   s_tuser,   // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // result, x_cell, y_cell, x_frac, y_frac
  output logic [0:0]   m_tuser,   // saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  bml_pkg::cmd_t cmd;
  bml_pkg::sts_t sts;
  logic          ctrl_ready;
  logic [31:0]   result;
  logic          saturated;
  logic [3:0]    x_cell, y_cell;
  logic [15:0]   x_frac, y_frac;

  assign cfg_ready = 1'b1;
  assign s_tready  = ctrl_ready;
  assign m_tdata   = {y_frac, x_frac, y_cell, x_cell, result};
  assign m_tuser   = saturated;

  bml_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .s_tready (ctrl_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bml_dp #(
    .MAX_X_POINTS (MAX_X_POINTS),
    .MAX_Y_POINTS (MAX_Y_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (s_tuser),
    .entry_index (s_tdata[7:0]),
    .entry_data  (s_tdata[39:8]),
    .x_value     (s_tdata[71:40]),
    .y_value     (s_tdata[103:72]),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .result      (result),
    .saturated   (saturated),
    .x_cell      (x_cell),
    .y_cell      (y_cell),
    .x_frac      (x_frac),
    .y_frac      (y_frac)
  );

endmodule

[tb/bilinear_map_lookup_tb.sv]
// bilinear_map_lookup_tb: self-checking bench for the bilinear calibration-map lookup
// depends on bml_pkg and bilinear_map_lookup; predicts every lookup in its own map copy
module bilinear_map_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // codes with no meaning in the block, to exercise the fallbacks
  localparam logic [2:0] CT_RSVD_A  = 3'd5;
  localparam logic [2:0] CT_RSVD_B  = 3'd7;
  localparam logic [1:0] RM_RSVD    = 2'd3;
  localparam logic [2:0] REG_RSVD_A = 3'd6;
  localparam logic [2:0] REG_RSVD_B = 3'd7;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [31:0] data;
    logic [31:0] xv;
    logic [31:0] yv;
  } map_item_t;

  typedef struct {
    logic [31:0] value;
    logic        sat;
    logic [3:0]  xc;
    logic [3:0]  yc;
    logic [15:0] xf;
    logic [15:0] yf;
  } lookup_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;   // entry_index, entry_data, x_value, y_value
  logic [1:0]   s_tuser = bml_pkg::OP_LOOKUP;   // operation
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;   // result, x_cell, y_cell, x_frac, y_frac
  logic [0:0]   m_tuser;   // saturated
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  bilinear_map_lookup dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bench copy of the map and registers
  logic [31:0] xbp [16];
  logic [31:0] ybp [16];
  logic [31:0] cells [256];
  logic [4:0]  xcount_r = 5'd1, ycount_r = 5'd1;
  logic [2:0]  ctype_r = bml_pkg::CT_Q16;
  logic [1:0]  rmode_r = bml_pkg::RM_TYPED;
  logic [31:0] scale_r = 32'd65536, offset_r = 32'd0;

  map_item_t   item_q [$];
  lookup_res_t lookup_expect_q [$];
  map_item_t   drv_item;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          mismatches = 0;
  int          cyc = 0;
  bit          calm = 1'b0;
  logic        hold = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_count(logic [4:0] c);
    if (c == 0) return 1;
    if (c > 16) return 16;
    return c;
  endfunction

  function automatic longint bp_at(bit yax, int k);
    return yax ? longint'($signed(ybp[k])) : longint'($signed(xbp[k]));
  endfunction

  function automatic void find_interval(input bit yax, input int n, input longint v,
                                        output int idx, output logic [15:0] frac);
    longint lo, hi, q;
    int k;
    idx = 0;
    frac = '0;
    k = 0;
    if (v >= bp_at(yax, n - 1)) begin
      idx = n - 1;
      return;
    end
    if (v < bp_at(yax, 0)) return;
    while (k + 1 < n && !(bp_at(yax, k) <= v && v < bp_at(yax, k + 1))) k++;
    if (k + 1 >= n) begin
      idx = n - 1;
      return;
    end
    lo = bp_at(yax, k);
    hi = bp_at(yax, k + 1);
    idx = k;
    q = ((v - lo) * 65536) / (hi - lo);
    frac = q[15:0];
  endfunction

  function automatic longint cell_q16(logic [31:0] w, int kind);
    case (kind)
      bml_pkg::CT_U8:  return longint'(w[7:0]) * 65536;
      bml_pkg::CT_U16: return longint'(w[15:0]) * 65536;
      bml_pkg::CT_S8:  return longint'($signed(w[7:0])) * 65536;
      bml_pkg::CT_S16: return longint'($signed(w[15:0])) * 65536;
      default: return longint'($signed(w));
    endcase
  endfunction

  function automatic longint blend(longint a, longint b, logic [15:0] f);
    return a + (((b - a) * longint'(f)) >>> 16);
  endfunction

  // update the map copy or queue the predicted lookup result
  function automatic void apply_item(map_item_t it);
    int cx, cy, ix, iy, ix1, iy1, kind, mode;
    logic [15:0] tx, ty;
    longint r0, r1, interp, res;
    lookup_res_t e;
    case (it.op)
      bml_pkg::OP_WR_X:    if (it.idx < 16) xbp[it.idx] = it.data;
      bml_pkg::OP_WR_Y:    if (it.idx < 16) ybp[it.idx] = it.data;
      bml_pkg::OP_WR_CELL: cells[it.idx] = it.data;
      default: begin
        cx = eff_count(xcount_r);
        cy = eff_count(ycount_r);
        find_interval(1'b0, cx, longint'($signed(it.xv)), ix, tx);
        find_interval(1'b1, cy, longint'($signed(it.yv)), iy, ty);
        ix1 = (ix + 1 < cx) ? ix + 1 : ix;
        iy1 = (iy + 1 < cy) ? iy + 1 : iy;
        mode = (rmode_r == bml_pkg::RM_U8 || rmode_r == bml_pkg::RM_U16) ?
               rmode_r : bml_pkg::RM_TYPED;
        if (mode == bml_pkg::RM_U8) kind = bml_pkg::CT_U8;
        else if (mode == bml_pkg::RM_U16) kind = bml_pkg::CT_U16;
        else kind = (ctype_r <= bml_pkg::CT_S16) ? ctype_r : bml_pkg::CT_Q16;
        r0 = blend(cell_q16(cells[iy * cx + ix], kind), cell_q16(cells[iy * cx + ix1], kind),
                   tx);
        r1 = blend(cell_q16(cells[iy1 * cx + ix], kind), cell_q16(cells[iy1 * cx + ix1], kind),
                   tx);
        interp = blend(r0, r1, ty);
        e.sat = 1'b0;
        if (mode == bml_pkg::RM_U8) res = longint'(interp[23:16]);
        else if (mode == bml_pkg::RM_U16) res = longint'(interp[31:16]);
        else if (kind == bml_pkg::CT_Q16) res = interp;
        else begin
          res = ((longint'($signed(scale_r)) * interp) >>> 16) + longint'($signed(offset_r));
          if (res > 64'sd2147483647) begin
            res = 64'sd2147483647;
            e.sat = 1'b1;
          end
          if (res < -64'sd2147483648) begin
            res = -64'sd2147483648;
            e.sat = 1'b1;
          end
        end
        e.value = res[31:0];
        e.xc = ix[3:0];
        e.yc = iy[3:0];
        e.xf = tx;
        e.yf = ty;
        lookup_expect_q.push_back(e);
      end
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    bit fire;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        apply_item(drv_item);
        send_gap = pick_gap();
      end
      if (!s_tvalid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (item_q.size() > 0) begin
          drv_item = item_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {drv_item.yv, drv_item.xv, drv_item.data, drv_item.idx};
          s_tuser <= drv_item.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  always @(posedge clk) begin
    cyc++;
    hold <= (cyc >= 4000 && cyc < 4800);
  end

  // receiver and checker
  always @(posedge clk) begin
    lookup_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (lookup_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h %b", m_tdata, m_tuser);
      end else begin
        e = lookup_expect_q.pop_front();
        if (m_tdata[31:0] !== e.value || m_tuser[0] !== e.sat || m_tdata[35:32] !== e.xc ||
            m_tdata[39:36] !== e.yc || m_tdata[55:40] !== e.xf || m_tdata[71:56] !== e.yf) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp res=%h sat=%b xc=%0d yc=%0d xf=%h yf=%h, ",
                      "got res=%h sat=%b xc=%0d yc=%0d xf=%h yf=%h"},
                     e.value, e.sat, e.xc, e.yc, e.xf, e.yf, m_tdata[31:0], m_tuser[0],
                     m_tdata[35:32], m_tdata[39:36], m_tdata[55:40], m_tdata[71:56]);
        end
      end
    end
    if (rst || hold) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) recv_gap = pick_gap();
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bml_pkg::REG_X_COUNT:     xcount_r = val[4:0];
      bml_pkg::REG_Y_COUNT:     ycount_r = val[4:0];
      bml_pkg::REG_CELL_TYPE:   ctype_r = val[2:0];
      bml_pkg::REG_RESULT_MODE: rmode_r = val[1:0];
      bml_pkg::REG_SCALE:       scale_r = val;
      bml_pkg::REG_OFFSET:      offset_r = val;
      default: ;
    endcase
  endtask

  // narrow registers get random upper bits, which the block drops
  task automatic set_config(int xc, int yc, int ct, int rm, logic [31:0] sc, logic [31:0] of);
    cfg_write(bml_pkg::REG_X_COUNT, ($urandom & ~32'h1F) | xc);
    cfg_write(bml_pkg::REG_Y_COUNT, ($urandom & ~32'h1F) | yc);
    cfg_write(bml_pkg::REG_CELL_TYPE, ($urandom & ~32'h7) | ct);
    cfg_write(bml_pkg::REG_RESULT_MODE, ($urandom & ~32'h3) | rm);
    cfg_write(bml_pkg::REG_SCALE, sc);
    cfg_write(bml_pkg::REG_OFFSET, of);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (item_q.size() != 0 || s_tvalid || lookup_expect_q.size() != 0);
    repeat (120) @(posedge clk);
  endtask

  function automatic void push(logic [1:0] op, logic [7:0] idx, logic [31:0] data,
                               logic [31:0] xv, logic [31:0] yv);
    map_item_t it;
    it.op = op;
    it.idx = idx;
    it.data = data;
    it.xv = xv;
    it.yv = yv;
    item_q.push_back(it);
  endfunction

  function automatic void lookup(logic [31:0] xv, logic [31:0] yv);
    push(bml_pkg::OP_LOOKUP, 8'($urandom), $urandom, xv, yv);
  endfunction

  // ascending breakpoints on both axes, or arbitrary ones when shuffled
  function automatic void load_axes(int spread, bit shuffled);
    longint v;
    for (int a = 0; a < 2; a++) begin
      v = -longint'($urandom_range(0, 1 << 30));
      for (int k = 0; k < 16; k++) begin
        push(a ? bml_pkg::OP_WR_Y : bml_pkg::OP_WR_X, 8'(k), shuffled ? $urandom : v[31:0],
             $urandom, $urandom);
        v += $urandom_range(1, spread);
      end
    end
  endfunction

  // coordinate near the item's view of the axis at issue time
  function automatic logic [31:0] pick_coord(bit yax, int n);
    int r, k;
    longint lo, hi;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, n - 1);
    lo = bp_at(yax, k);
    hi = (k + 1 < n) ? bp_at(yax, k + 1) : lo + 16;
    if (r < 20) return lo[31:0];
    if (r < 60 && hi > lo) begin
      lo = lo + longint'($urandom) % (hi - lo);
      return lo[31:0];
    end
    if (r < 70) return lo[31:0] - 1;
    if (r < 75) return 32'h8000_0000;
    if (r < 80) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  int spreads [3] = '{8, 1 << 20, 1 << 26};

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every store entry before any lookup
    load_axes(1 << 20, 1'b0);
    for (int c = 0; c < 256; c++) push(bml_pkg::OP_WR_CELL, 8'(c), $urandom, $urandom, $urandom);
    drain();

    // directed: end points, exact breakpoints, extremes, ignored writes
    set_config(16, 16, bml_pkg::CT_S16, bml_pkg::RM_TYPED, 32'd65536, 32'd0);
    lookup(32'h8000_0000, 32'h7FFF_FFFF);
    lookup(32'h7FFF_FFFF, 32'h8000_0000);
    lookup(xbp[0], ybp[0]);
    lookup(xbp[15], ybp[15]);
    lookup(xbp[0] - 1, ybp[15] - 1);
    lookup(xbp[7], ybp[8] + 1);
    lookup(xbp[14] + 3, ybp[1] - 1);
    push(bml_pkg::OP_WR_X, 8'd16, $urandom, 32'h0, 32'h0);
    push(bml_pkg::OP_WR_X, 8'd255, 32'hFFFF_FFFF, 32'h0, 32'h0);
    push(bml_pkg::OP_WR_Y, 8'd200, 32'h8000_0000, 32'h0, 32'h0);
    push(bml_pkg::OP_WR_CELL, 8'd255, 32'h7FFF_FFFF, 32'h0, 32'h0);
    push(bml_pkg::OP_WR_CELL, 8'd0, 32'h8000_8080, 32'h0, 32'h0);
    push(bml_pkg::OP_WR_CELL, 8'd1, 32'h0000_FFFF, 32'h0, 32'h0);
    push(bml_pkg::OP_WR_CELL, 8'd16, 32'hFFFF_7F7F, 32'h0, 32'h0);
    push(bml_pkg::OP_WR_CELL, 8'd17, 32'h0000_0000, 32'h0, 32'h0);
    lookup(xbp[0] + 1, ybp[0] + 1);
    lookup(xbp[15] - 1, ybp[15] - 1);
    lookup(xbp[0] + (xbp[1] - xbp[0]) / 2, ybp[0] + (ybp[1] - ybp[0]) / 2);
    lookup(32'h0, 32'h0);
    drain();
    set_config(1, 1, bml_pkg::CT_Q16, bml_pkg::RM_TYPED, 32'd65536, 32'd0);
    lookup(32'h8000_0000, 32'h8000_0000);
    lookup(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    lookup($urandom, $urandom);
    drain();
    cfg_write(REG_RSVD_A, $urandom);
    cfg_write(REG_RSVD_B, $urandom);
    cfg_valid <= 1'b0;

    for (int p = 0; p < 10; p++) begin
      drain();
      case (p)
        0: set_config(16, 16, bml_pkg::CT_Q16, bml_pkg::RM_TYPED, 32'd65536, 32'd0);
        1: set_config(4, 5, bml_pkg::CT_U8, bml_pkg::RM_TYPED, 32'h8000_0000, 32'h7FFF_FFFF);
        2: set_config(2, 16, bml_pkg::CT_U16, bml_pkg::RM_TYPED, 32'h7FFF_FFFF, 32'h8000_0000);
        3: set_config(16, 3, bml_pkg::CT_S8, bml_pkg::RM_TYPED, $urandom, $urandom);
        4: set_config(1, 1, bml_pkg::CT_S16, bml_pkg::RM_TYPED, 32'd65536, 32'hFFFF_FFFB);
        5: set_config(0, 31, bml_pkg::CT_S16, bml_pkg::RM_TYPED, $urandom, $urandom);
        6: set_config(8, 8, CT_RSVD_A, RM_RSVD, $urandom, $urandom);
        7: set_config(16, 16, CT_RSVD_B, bml_pkg::RM_U8, $urandom, $urandom);
        8: set_config(13, 9, bml_pkg::CT_Q16, bml_pkg::RM_U16, $urandom, $urandom);
        default: set_config(16, 16, bml_pkg::CT_S8, bml_pkg::RM_TYPED, $urandom, $urandom);
      endcase
      calm = (p == 3 || p == 7);
      load_axes(spreads[p % 3], p == 5);
      // wait for the reload so coordinates follow the new axes
      drain();
      for (int i = 0; i < 100; i++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 78) lookup(pick_coord(1'b0, eff_count(xcount_r)),
                           pick_coord(1'b1, eff_count(ycount_r)));
        else if (r < 94) push(bml_pkg::OP_WR_CELL, 8'($urandom), $urandom, $urandom, $urandom);
        else if (r < 97) push(bml_pkg::OP_WR_X, 8'($urandom_range(0, 20)), $urandom, $urandom,
                              $urandom);
        else push(bml_pkg::OP_WR_Y, 8'($urandom_range(0, 20)), $urandom, $urandom, $urandom);
        // keep the queue short so coordinates track recent writes
        while (item_q.size() > 8) @(posedge clk);
      end
    end
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && lookup_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
